@@ rtl/skf_pkg.sv @@
// Shared widths, reset values, register indexes and types for the scalar Kalman filter.
package skf_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;

    localparam int EST_W  = 40;
    localparam int COV_W  = 32;
    localparam int GAIN_W = 25;
    localparam int DEN_W  = COV_W + 1;
    localparam int NUM_W  = COV_W + GAIN_W;
    localparam int DIFF_W = 49;
    localparam int MAG_W  = DIFF_W - 1;
    localparam int HALF_W = MAG_W / 2;
    localparam int PROD_W = COV_W + GAIN_W;
    localparam int CORR_W = MAG_W + 1;

    localparam logic [GAIN_W-1:0] ONE_Q24  = GAIN_W'(1) << (GAIN_W - 1);
    localparam logic [GAIN_W-1:0] HALF_Q24 = GAIN_W'(1) << (GAIN_W - 2);

    localparam logic [COV_W-1:0] Q_RESET = 32'd301990;
    localparam logic [COV_W-1:0] R_RESET = 32'd9093251;
    localparam logic [COV_W-1:0] P_RESET = 32'd335544;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COV_W;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } skf_div_stat_t;

endpackage

@@ rtl/skf_div.sv @@
// Radix-2 restoring divider producing the Q1.24 gain quotient; rounding comes from the numerator.
module skf_div
    import skf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output skf_div_stat_t     stat,
    output logic [GAIN_W-1:0] quot
);

    localparam int CNT_W = $clog2(GAIN_W + 1);

    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [GAIN_W-1:0] sh_reg;
    logic [GAIN_W-1:0] sh_next;
    logic [DEN_W-1:0]  den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] trial_sub;
    logic           trial_ge;

    assign trial     = {rem_reg, sh_reg[GAIN_W-1]};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_comb
    begin
        rem_next = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        sh_next  = {sh_reg[GAIN_W-2:0], trial_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(GAIN_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DEN_W'(num[NUM_W-1:GAIN_W]);
            sh_reg  <= num[GAIN_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = sh_reg;

endmodule

@@ rtl/scalar_kalman_filter.sv @@
// Top level of the scalar Kalman filter: sequencer, shared multiplier and filter state.
//
//   channel | signals                              | direction | handshake
//   --------+--------------------------------------+-----------+-------------------
//   in      | depth_sample                         | into      | in_valid/in_ready
//   out     | filtered_estimate, error_covariance  | out of    | out_valid/out_ready
//   cfg     | cfg_index, cfg_data                  | into      | cfg_we, no wait
//
// A transaction steps from acceptance through setup (S_PREP, S_DIVST), the radix-2
// gain divider (25 quotient bits, one per cycle, then a done pulse), 3 passes through the
// shared 32x25 multiplier and a write-back in S_EST, then returns to idle for the next input.
// Reset clears the sequencer, loads the noise registers and sets the state to
// estimate zero and covariance 0.02.
// A result waiting on out_ready stalls only the final write-back; the next input
// transaction is taken while the result is still held.
module scalar_kalman_filter
    import skf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_WIDTH-1:0] depth_sample,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [EST_W-1:0]        filtered_estimate,
    output logic [COV_W-1:0]        error_covariance,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_DIVST = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MLO   = 3'd4;
    localparam logic [2:0] S_MHI   = 3'd5;
    localparam logic [2:0] S_MCOV  = 3'd6;
    localparam logic [2:0] S_EST   = 3'd7;

    localparam int EXT_W = CORR_W + 1;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [COV_W-1:0]  process_noise_reg;
    logic [COV_W-1:0]  measure_noise_reg;
    logic [EST_W-1:0]  est_reg;
    logic [COV_W-1:0]  cov_reg;
    logic              out_valid_reg;

    logic [DIFF_W-1:0] meas_reg;
    logic [COV_W-1:0]  p_mid_reg;
    logic [DEN_W-1:0]  denom_reg;
    logic [DIFF_W-1:0] diff_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [GAIN_W-1:0] lo_reg;
    logic [CORR_W-1:0] corr_reg;

    logic              accept;
    logic              out_load;
    logic [DEN_W-1:0]  p_sum;
    logic [COV_W-1:0]  p_mid;
    logic [DIFF_W-1:0] meas;
    logic [DIFF_W-1:0] mag_full;
    logic [NUM_W-1:0]  num;
    logic              mul_en;
    logic [COV_W-1:0]  mul_a;
    logic [GAIN_W-1:0] mul_b;
    logic [CORR_W-1:0] lo_sum;
    logic [PROD_W-2:0] cov_sum;
    logic [EXT_W-1:0]  est_ext;
    logic [EXT_W-1:0]  corr_ext;
    logic [EXT_W-1:0]  x_full;
    logic [EST_W-1:0]  x_sat;

    skf_div_stat_t     div_stat;
    logic [GAIN_W-1:0] div_quot;
    logic              div_start;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_EST) && (!out_valid_reg || out_ready);
    assign div_start = (state_reg == S_DIVST);

    assign p_sum = {1'b0, cov_reg} + {1'b0, process_noise_reg};
    assign p_mid = p_sum[COV_W] ? {COV_W{1'b1}} : p_sum[COV_W-1:0];
    assign meas  = {{(DIFF_W - 16 - SAMPLE_WIDTH){depth_sample[SAMPLE_WIDTH-1]}},
                    depth_sample, 16'd0};
    assign mag_full = diff_reg[DIFF_W-1] ? (~diff_reg + DIFF_W'(1)) : diff_reg;
    assign num      = NUM_W'({p_mid_reg, {(GAIN_W - 1){1'b0}}})
                    + NUM_W'(denom_reg[DEN_W-1:1]);

    skf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (denom_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = gain_reg;
        unique case (state_reg)
            S_MLO:
            begin
                mul_en = 1'b1;
                mul_a  = COV_W'(mag_reg[HALF_W-1:0]);
            end
            S_MHI:
            begin
                mul_en = 1'b1;
                mul_a  = COV_W'(mag_reg[MAG_W-1:HALF_W]);
            end
            S_MCOV:
            begin
                mul_en = 1'b1;
                mul_a  = p_mid_reg;
                mul_b  = ONE_Q24 - gain_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign lo_sum  = CORR_W'(prod_reg[CORR_W-1:0]) + CORR_W'(HALF_Q24);
    assign cov_sum = prod_reg[PROD_W-2:0] + (PROD_W-1)'(HALF_Q24);

    always_comb
    begin
        est_ext  = {{(EXT_W - EST_W){est_reg[EST_W-1]}}, est_reg};
        corr_ext = {1'b0, corr_reg};
        x_full   = diff_reg[DIFF_W-1] ? (est_ext - corr_ext) : (est_ext + corr_ext);
        if (!x_full[EXT_W-1] && (x_full[EXT_W-2:EST_W-1] != '0))
            x_sat = {1'b0, {(EST_W - 1){1'b1}}};
        else if (x_full[EXT_W-1] && (x_full[EXT_W-2:EST_W-1] != '1))
            x_sat = {1'b1, {(EST_W - 1){1'b0}}};
        else
            x_sat = x_full[EST_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_PREP;
            S_PREP:  state_next = S_DIVST;
            S_DIVST: state_next = S_DIV;
            S_DIV:   if (div_stat.done) state_next = S_MLO;
            S_MLO:   state_next = S_MHI;
            S_MHI:   state_next = S_MCOV;
            S_MCOV:  state_next = S_EST;
            S_EST:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            process_noise_reg <= Q_RESET;
            measure_noise_reg <= R_RESET;
            est_reg           <= '0;
            cov_reg           <= P_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PROCESS_NOISE: process_noise_reg <= cfg_data;
                    REG_MEASURE_NOISE: measure_noise_reg <= cfg_data;
                    default:           process_noise_reg <= process_noise_reg;
                endcase
            end
            if (out_load)
            begin
                est_reg       <= x_sat;
                cov_reg       <= cov_sum[COV_W+GAIN_W-2:GAIN_W-1];
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meas_reg  <= meas;
            p_mid_reg <= p_mid;
        end
        if (state_reg == S_PREP)
        begin
            denom_reg <= {1'b0, p_mid_reg} + {1'b0, measure_noise_reg};
            diff_reg  <= meas_reg - {{(DIFF_W - EST_W){est_reg[EST_W-1]}}, est_reg};
        end
        if (state_reg == S_DIVST)
            mag_reg <= mag_full[MAG_W-1:0];
        if ((state_reg == S_DIV) && div_stat.done)
        begin
            if (denom_reg == '0)
                gain_reg <= '0;
            else if (div_quot > ONE_Q24)
                gain_reg <= ONE_Q24;
            else
                gain_reg <= div_quot;
        end
        if (mul_en)
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (state_reg == S_MHI)
            lo_reg <= lo_sum[CORR_W-1:GAIN_W-1];
        if (state_reg == S_MCOV)
            corr_reg <= CORR_W'(prod_reg[MAG_W-1:0]) + CORR_W'(lo_reg);
    end

    assign out_valid         = out_valid_reg;
    assign filtered_estimate = est_reg;
    assign error_covariance  = cov_reg;

`ifndef ASSERT_OFF
    a_cov_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (error_covariance <= $past(p_mid_reg)))
        else $error("covariance update exceeds predicted covariance");

    a_gain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MLO) |-> (gain_reg <= ONE_Q24))
        else $error("gain above one");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide wait");

    a_div_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (div_stat.busy && (state_reg == S_DIV)))
        else $error("divider not running after start");
`endif

endmodule
